/* design/flwm_pkg.sv */
// ----------------------------------------------------------------------------
// flwm_pkg
// shared types and constants of the free level window monitor
// ----------------------------------------------------------------------------
package flwm_pkg;

  localparam int REG_IDX_W  = 2;
  localparam int NUM_W      = 80;
  localparam int DEN_W      = 52;
  localparam int QUO_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [19:0] US_PER_SEC = 20'd1000000;

  localparam logic [1:0] LVL_NORMAL = 2'd0;
  localparam logic [1:0] LVL_WARN   = 2'd1;
  localparam logic [1:0] LVL_CRIT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INT_WARN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_CRIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_WARN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXT_CRIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HIST_LEN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAG_EN  = 3'd7;

  typedef struct packed {
    logic                 region_sel;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [31:0]          free_bytes;
    logic [31:0]          largest_block;
    logic [47:0]          time_us;
    logic [31:0]          warn_thr;
    logic [31:0]          crit_thr;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FRAG,
    S_WALK,
    S_MEAN,
    S_FMEAN,
    S_RATE,
    S_SLOPE,
    S_PROJ_LO,
    S_PROJ_HI,
    S_PROJ_DIV,
    S_WAIT,
    S_STORE,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_FRAG,
    OP_MEAN,
    OP_FMEAN,
    OP_SLOPE,
    OP_WARN,
    OP_CRIT
  } op_t;

endpackage

/* design/flwm_if.sv */
// ----------------------------------------------------------------------------
// flwm_if
// sample and result channels of the free level window monitor
// ----------------------------------------------------------------------------
interface flwm_in_if;
  logic        valid;
  logic        ready;
  logic        region_sel;
  logic [31:0] free_bytes;
  logic [31:0] largest_block;
  logic [47:0] time_us;

  modport source (output valid, region_sel, free_bytes, largest_block, time_us,
                  input ready);
  modport sink (input valid, region_sel, free_bytes, largest_block, time_us,
                output ready);
endinterface

interface flwm_out_if;
  logic               valid;
  logic               ready;
  logic               region_out;
  logic [1:0]         alarm_level;
  logic               level_changed;
  logic [31:0]        window_min;
  logic [31:0]        window_max;
  logic [31:0]        window_mean;
  logic [15:0]        frag_now;
  logic [15:0]        frag_mean;
  logic signed [32:0] slope_bps;
  logic [31:0]        secs_to_warn;
  logic [31:0]        secs_to_critical;

  modport source (output valid, region_out, alarm_level, level_changed, window_min,
                  window_max, window_mean, frag_now, frag_mean, slope_bps,
                  secs_to_warn, secs_to_critical, input ready);
  modport sink (input valid, region_out, alarm_level, level_changed, window_min,
                window_max, window_mean, frag_now, frag_mean, slope_bps,
                secs_to_warn, secs_to_critical, output ready);
endinterface

/* design/flwm_front.sv */
// ----------------------------------------------------------------------------
// flwm_front
// accepts samples, maps the region to its storage and picks its thresholds
// ----------------------------------------------------------------------------
module flwm_front #(
  parameter int REGION_COUNT = 2
) (
  flwm_in_if.sink          in_ch,
  input  logic             fifo_full,
  input  logic [31:0]      int_warn,
  input  logic [31:0]      int_crit,
  input  logic [31:0]      ext_warn,
  input  logic [31:0]      ext_crit,
  output logic             push,
  output flwm_pkg::item_t  item
);

  assign in_ch.ready = !fifo_full;
  assign push        = in_ch.valid && !fifo_full;

  always_comb begin
    item.region_sel    = in_ch.region_sel;
    item.reg_idx       = (REGION_COUNT > 1) ? {1'b0, in_ch.region_sel} : '0;
    item.free_bytes    = in_ch.free_bytes;
    item.largest_block = in_ch.largest_block;
    item.time_us       = in_ch.time_us;
    item.warn_thr      = in_ch.region_sel ? ext_warn : int_warn;
    item.crit_thr      = in_ch.region_sel ? ext_crit : int_crit;
  end

endmodule

/* design/flwm_fifo.sv */
// ----------------------------------------------------------------------------
// flwm_fifo
// two-entry item queue between front and back
// ----------------------------------------------------------------------------
module flwm_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  flwm_pkg::item_t item_in,
  output logic            full,
  output logic            valid,
  output flwm_pkg::item_t item_out,
  input  logic            pop
);

  flwm_pkg::item_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign item_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

/* design/flwm_div.sv */
// ----------------------------------------------------------------------------
// flwm_div
// shared restoring divider, one quotient bit per cycle, saturating quotient
// ----------------------------------------------------------------------------
module flwm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  flwm_pkg::div_req_t req,
  output flwm_pkg::div_rsp_t rsp
);

  localparam int NW = flwm_pkg::NUM_W;
  localparam int DW = flwm_pkg::DEN_W;
  localparam int QW = flwm_pkg::QUO_W;

  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [QW-1:0] low_r;
  logic [QW-1:0] quo_r;
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          ge;
  logic          over;

  assign trial = {rem_r, low_r[QW-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign over  = ({{(DW-(NW-QW)){1'b0}}, req.num[NW-1:QW]} >= req.den);

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= !over;
        done_r <= over;
        cnt_r  <= 6'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= DW'(req.num[NW-1:QW]);
      low_r <= req.num[QW-1:0];
      den_r <= req.den;
      quo_r <= over ? '1 : '0;
    end else if (busy_r) begin
      rem_r <= ge ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      low_r <= {low_r[QW-2:0], 1'b0};
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

endmodule

/* design/flwm_back.sv */
// ----------------------------------------------------------------------------
// flwm_back
// per-sample sequencer: history ring walk, divisions, alarm levels, result
// ----------------------------------------------------------------------------
module flwm_back #(
  parameter int HIST_DEPTH   = 64,
  parameter int REGION_COUNT = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  flwm_pkg::item_t q_item,
  output logic            q_pop,
  input  logic [31:0]     hyst,
  input  logic [6:0]      win_len,
  input  logic [6:0]      hist_len,
  input  logic            frag_en,
  flwm_out_if.source      out_ch
);

  localparam int DEPTH_W   = $clog2(HIST_DEPTH);
  localparam int FILL_W    = $clog2(HIST_DEPTH + 1);
  localparam int REG_W     = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int MEM_DEPTH = REGION_COUNT * HIST_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CW        = (FILL_W + 1 > 7) ? FILL_W + 1 : 7;

  typedef struct packed {
    logic [31:0] free_val;
    logic [47:0] stamp;
    logic [15:0] frag;
  } ring_word_t;

  flwm_pkg::state_t state_r, state_nxt, ret_r;
  flwm_pkg::op_t    op_r;
  flwm_pkg::item_t  it_r;
  flwm_pkg::div_req_t div_req;
  flwm_pkg::div_rsp_t div_rsp;

  ring_word_t        mem [MEM_DEPTH];
  ring_word_t        rd_data_r;
  logic              rd_valid_r;
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] base, rd_addr, wr_addr;

  logic [1:0]         level_r [REGION_COUNT];
  logic [DEPTH_W-1:0] head_r  [REGION_COUNT];
  logic [FILL_W-1:0]  fill_r  [REGION_COUNT];

  logic [6:0]         n_r, iss_r, acc_r;
  logic [DEPTH_W-1:0] ptr_r;
  logic [38:0]        sum_r;
  logic [22:0]        fsum_r;
  logic [31:0]        wmin_r, wmax_r, first_free_r;
  logic [47:0]        first_t_r;
  logic [15:0]        frag_r, fmean_r;
  logic [31:0]        mean_r, sw_r, sc_r;
  logic [32:0]        slope_r;
  logic [51:0]        den_r;
  logic [47:0]        dus_r;
  logic               falling_r, phase_r;
  logic [55:0]        plo_r, phi_r;

  logic [REG_W-1:0]   q_reg, it_reg;
  logic [FILL_W-1:0]  q_fill;
  logic [DEPTH_W-1:0] q_head, it_head;
  logic [CW-1:0]      fill_p1, hlen, st_p1;
  logic [6:0]         n_calc;
  logic               frag_ok, rate_ok, proj_ok, falling_c;
  logic [47:0]        dus_c;
  logic [31:0]        drop_c, thr_c, diff_c;
  flwm_pkg::state_t   after_frag;
  logic [1:0]         cur_lvl, nlvl;

  logic [31:0] o_min_r, o_max_r, o_mean_r, o_sw_r, o_sc_r;
  logic [15:0] o_frag_r, o_fmean_r;
  logic [32:0] o_slope_r;
  logic        o_sel_r, o_chg_r;
  logic [1:0]  o_lvl_r;

  function automatic logic [1:0] next_level(input logic [1:0] cur, input logic [31:0] warn,
                                            input logic [31:0] crit, input logic [31:0] fb,
                                            input logic [31:0] hy);
    logic [32:0] wsum, csum;
    logic [31:0] wrec, crec;
    logic [1:0]  res;
    wsum = {1'b0, warn} + {1'b0, hy};
    csum = {1'b0, crit} + {1'b0, hy};
    wrec = wsum[32] ? '1 : wsum[31:0];
    crec = csum[32] ? '1 : csum[31:0];
    priority if (cur == flwm_pkg::LVL_WARN) begin
      priority if (crit != 0 && fb <= crit) res = flwm_pkg::LVL_CRIT;
      else if (warn == 0 || fb > wrec) res = flwm_pkg::LVL_NORMAL;
      else res = flwm_pkg::LVL_WARN;
    end else if (cur == flwm_pkg::LVL_CRIT) begin
      priority if (crit == 0) begin
        res = (warn != 0 && fb <= warn) ? flwm_pkg::LVL_WARN : flwm_pkg::LVL_NORMAL;
      end else if (fb <= crit || fb <= crec) res = flwm_pkg::LVL_CRIT;
      else if (warn != 0 && fb <= wrec) res = flwm_pkg::LVL_WARN;
      else res = flwm_pkg::LVL_NORMAL;
    end else begin
      priority if (crit != 0 && fb <= crit) res = flwm_pkg::LVL_CRIT;
      else if (warn != 0 && fb <= warn) res = flwm_pkg::LVL_WARN;
      else res = flwm_pkg::LVL_NORMAL;
    end
    return res;
  endfunction

  flwm_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // derived values
  always_comb begin
    q_reg   = q_item.reg_idx[REG_W-1:0];
    it_reg  = it_r.reg_idx[REG_W-1:0];
    q_fill  = fill_r[q_reg];
    q_head  = head_r[q_reg];
    it_head = head_r[it_reg];
    fill_p1 = CW'(q_fill) + CW'(1);
    n_calc  = (CW'(win_len) < fill_p1) ? win_len : fill_p1[6:0];
    hlen    = (CW'(hist_len) < CW'(HIST_DEPTH)) ? CW'(hist_len) : CW'(HIST_DEPTH);
    st_p1   = CW'(fill_r[it_reg]) + CW'(1);
    base    = ADDR_W'(it_reg) * ADDR_W'(HIST_DEPTH);
    rd_addr = base + ADDR_W'(ptr_r);
    wr_addr = base + ADDR_W'(it_head);
    frag_ok = frag_en && (it_r.free_bytes != 0) && (it_r.largest_block <= it_r.free_bytes);
    after_frag = (win_len == 7'd0) ? flwm_pkg::S_STORE : flwm_pkg::S_WALK;
    dus_c     = it_r.time_us - first_t_r;
    falling_c = it_r.free_bytes < first_free_r;
    drop_c    = falling_c ? first_free_r - it_r.free_bytes : it_r.free_bytes - first_free_r;
    rate_ok   = (n_r >= 7'd2) && (dus_c != 0) && (drop_c != 0);
    thr_c     = phase_r ? it_r.crit_thr : it_r.warn_thr;
    proj_ok   = (thr_c != 0) && (it_r.free_bytes > thr_c);
    diff_c    = it_r.free_bytes - thr_c;
    cur_lvl   = level_r[it_reg];
    nlvl      = (it_r.warn_thr != 0 || it_r.crit_thr != 0)
              ? next_level(cur_lvl, it_r.warn_thr, it_r.crit_thr, it_r.free_bytes, hyst)
              : cur_lvl;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      flwm_pkg::S_IDLE:     if (q_valid) state_nxt = flwm_pkg::S_FRAG;
      flwm_pkg::S_FRAG:     state_nxt = frag_ok ? flwm_pkg::S_WAIT : after_frag;
      flwm_pkg::S_WALK:     if (acc_r == 7'd0) state_nxt = flwm_pkg::S_MEAN;
      flwm_pkg::S_MEAN:     state_nxt = flwm_pkg::S_WAIT;
      flwm_pkg::S_FMEAN:    state_nxt = flwm_pkg::S_WAIT;
      flwm_pkg::S_RATE:     state_nxt = rate_ok ? flwm_pkg::S_SLOPE : flwm_pkg::S_STORE;
      flwm_pkg::S_SLOPE:    state_nxt = flwm_pkg::S_WAIT;
      flwm_pkg::S_PROJ_LO: begin
        if (proj_ok) state_nxt = flwm_pkg::S_PROJ_HI;
        else if (phase_r) state_nxt = flwm_pkg::S_STORE;
      end
      flwm_pkg::S_PROJ_HI:  state_nxt = flwm_pkg::S_PROJ_DIV;
      flwm_pkg::S_PROJ_DIV: state_nxt = flwm_pkg::S_WAIT;
      flwm_pkg::S_WAIT:     if (div_rsp.done) state_nxt = ret_r;
      flwm_pkg::S_STORE:    state_nxt = flwm_pkg::S_DONE;
      flwm_pkg::S_DONE:     if (out_ch.ready) state_nxt = flwm_pkg::S_IDLE;
      default:              state_nxt = flwm_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    div_req = '0;
    q_pop   = 1'b0;
    mem_re  = 1'b0;
    mem_we  = 1'b0;
    unique case (state_r)
      flwm_pkg::S_IDLE: q_pop = q_valid;
      flwm_pkg::S_FRAG: begin
        div_req.start = frag_ok;
        div_req.num   = 80'({it_r.free_bytes - it_r.largest_block, 16'h0000});
        div_req.den   = 52'(it_r.free_bytes);
      end
      flwm_pkg::S_WALK: mem_re = (iss_r != 7'd0);
      flwm_pkg::S_MEAN: begin
        div_req.start = 1'b1;
        div_req.num   = 80'(sum_r);
        div_req.den   = 52'(n_r);
      end
      flwm_pkg::S_FMEAN: begin
        div_req.start = 1'b1;
        div_req.num   = 80'(fsum_r + 23'(frag_r));
        div_req.den   = 52'(n_r);
      end
      flwm_pkg::S_SLOPE: begin
        div_req.start = 1'b1;
        div_req.num   = 80'(den_r);
        div_req.den   = 52'(dus_r);
      end
      flwm_pkg::S_PROJ_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = 80'(plo_r) + {phi_r, 24'h000000};
        div_req.den   = den_r;
      end
      flwm_pkg::S_STORE: mem_we = (hlen != '0);
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= flwm_pkg::S_IDLE;
      rd_valid_r <= 1'b0;
      iss_r      <= '0;
      acc_r      <= '0;
      for (int i = 0; i < REGION_COUNT; i++) begin
        level_r[i] <= flwm_pkg::LVL_NORMAL;
        head_r[i]  <= '0;
        fill_r[i]  <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= mem_re;
      if (q_pop) begin
        iss_r <= n_calc - 7'd1;
        acc_r <= n_calc - 7'd1;
      end
      if (mem_re) iss_r <= iss_r - 7'd1;
      if (rd_valid_r) acc_r <= acc_r - 7'd1;
      if (state_r == flwm_pkg::S_STORE) begin
        level_r[it_reg] <= nlvl;
        if (hlen != '0) begin
          head_r[it_reg] <= (it_head == DEPTH_W'(HIST_DEPTH - 1)) ? '0 : it_head + 1'b1;
          fill_r[it_reg] <= (st_p1 > hlen) ? FILL_W'(hlen) : FILL_W'(st_p1);
        end
      end
    end
  end

  // history ring
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= '{free_val: it_r.free_bytes, stamp: it_r.time_us,
                                   frag: frag_r};
    if (mem_re) rd_data_r <= mem[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      flwm_pkg::S_IDLE: begin
        if (q_valid) begin
          it_r         <= q_item;
          n_r          <= n_calc;
          ptr_r        <= (q_head == '0) ? DEPTH_W'(HIST_DEPTH - 1) : q_head - 1'b1;
          sum_r        <= 39'(q_item.free_bytes);
          fsum_r       <= '0;
          wmin_r       <= q_item.free_bytes;
          wmax_r       <= q_item.free_bytes;
          first_free_r <= q_item.free_bytes;
          first_t_r    <= q_item.time_us;
          slope_r      <= '0;
          sw_r         <= '0;
          sc_r         <= '0;
          phase_r      <= 1'b0;
        end
      end
      flwm_pkg::S_FRAG: begin
        frag_r <= '0;
        op_r   <= flwm_pkg::OP_FRAG;
        ret_r  <= after_frag;
      end
      flwm_pkg::S_WALK: begin
        if (mem_re) ptr_r <= (ptr_r == '0) ? DEPTH_W'(HIST_DEPTH - 1) : ptr_r - 1'b1;
        if (rd_valid_r) begin
          if (rd_data_r.free_val < wmin_r) wmin_r <= rd_data_r.free_val;
          if (rd_data_r.free_val > wmax_r) wmax_r <= rd_data_r.free_val;
          sum_r        <= sum_r + 39'(rd_data_r.free_val);
          fsum_r       <= fsum_r + 23'(rd_data_r.frag);
          first_free_r <= rd_data_r.free_val;
          first_t_r    <= rd_data_r.stamp;
        end
      end
      flwm_pkg::S_MEAN: begin
        op_r  <= flwm_pkg::OP_MEAN;
        ret_r <= flwm_pkg::S_FMEAN;
      end
      flwm_pkg::S_FMEAN: begin
        op_r  <= flwm_pkg::OP_FMEAN;
        ret_r <= flwm_pkg::S_RATE;
      end
      flwm_pkg::S_RATE: begin
        den_r     <= 52'(drop_c) * 52'(flwm_pkg::US_PER_SEC);
        dus_r     <= dus_c;
        falling_r <= falling_c;
      end
      flwm_pkg::S_SLOPE: begin
        op_r  <= flwm_pkg::OP_SLOPE;
        ret_r <= falling_r ? flwm_pkg::S_PROJ_LO : flwm_pkg::S_STORE;
      end
      flwm_pkg::S_PROJ_LO: begin
        plo_r <= 56'(diff_c) * 56'(dus_r[23:0]);
        if (!proj_ok) phase_r <= 1'b1;
      end
      flwm_pkg::S_PROJ_HI: phi_r <= 56'(diff_c) * 56'(dus_r[47:24]);
      flwm_pkg::S_PROJ_DIV: begin
        op_r    <= phase_r ? flwm_pkg::OP_CRIT : flwm_pkg::OP_WARN;
        ret_r   <= phase_r ? flwm_pkg::S_STORE : flwm_pkg::S_PROJ_LO;
        phase_r <= 1'b1;
      end
      flwm_pkg::S_WAIT: begin
        if (div_rsp.done) begin
          unique case (op_r)
            flwm_pkg::OP_FRAG:
              frag_r <= (div_rsp.quo > 32'd65535) ? 16'hffff : div_rsp.quo[15:0];
            flwm_pkg::OP_MEAN:  mean_r  <= div_rsp.quo;
            flwm_pkg::OP_FMEAN: fmean_r <= div_rsp.quo[15:0];
            flwm_pkg::OP_SLOPE:
              slope_r <= falling_r ? 33'(0) - {1'b0, div_rsp.quo} : {1'b0, div_rsp.quo};
            flwm_pkg::OP_WARN:  sw_r <= div_rsp.quo;
            flwm_pkg::OP_CRIT:  sc_r <= div_rsp.quo;
            default: ;
          endcase
        end
      end
      flwm_pkg::S_STORE: begin
        o_sel_r   <= it_r.region_sel;
        o_lvl_r   <= nlvl;
        o_chg_r   <= (nlvl != cur_lvl);
        o_frag_r  <= frag_r;
        o_min_r   <= (win_len != 7'd0) ? wmin_r : '0;
        o_max_r   <= (win_len != 7'd0) ? wmax_r : '0;
        o_mean_r  <= (win_len != 7'd0) ? mean_r : '0;
        o_fmean_r <= (win_len != 7'd0) ? fmean_r : '0;
        o_slope_r <= (win_len != 7'd0) ? slope_r : '0;
        o_sw_r    <= (win_len != 7'd0) ? sw_r : '0;
        o_sc_r    <= (win_len != 7'd0) ? sc_r : '0;
      end
      default: ;
    endcase
  end

  assign out_ch.valid            = (state_r == flwm_pkg::S_DONE);
  assign out_ch.region_out       = o_sel_r;
  assign out_ch.alarm_level      = o_lvl_r;
  assign out_ch.level_changed    = o_chg_r;
  assign out_ch.window_min       = o_min_r;
  assign out_ch.window_max       = o_max_r;
  assign out_ch.window_mean      = o_mean_r;
  assign out_ch.frag_now         = o_frag_r;
  assign out_ch.frag_mean        = o_fmean_r;
  assign out_ch.slope_bps        = $signed(o_slope_r);
  assign out_ch.secs_to_warn     = o_sw_r;
  assign out_ch.secs_to_critical = o_sc_r;

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_walk_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == flwm_pkg::S_WALK && state_nxt == flwm_pkg::S_MEAN) |-> !rd_valid_r)
    else $error("ring walk left with a read in flight");

  a_frag_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !frag_en) |-> (out_ch.frag_now == 16'd0))
    else $error("fragmentation reported while disabled");

endmodule

/* design/free_level_window_monitor_unit.sv */
// ----------------------------------------------------------------------------
// free_level_window_monitor_unit
// free memory monitor: alarm levels with hysteresis and window statistics
// ----------------------------------------------------------------------------
// channel   dir  handshake     content
// in_ch     in   valid/ready   region_sel, free_bytes, largest_block, time_us
// out_ch    out  valid/ready   level, window stats, fragmentation, slope, eta
// cfg_*     in   cfg_we        register index and 32-bit data, write only
//
// one item is worked at a time; each of up to six divisions on the shared
// 32-step divider runs through all its steps unless the quotient saturates,
// and the ring walk issues one read per stored entry of the window
// a two-entry queue takes new items while a result waits in the output register
// synchronous active-low reset, no clearing pass; ring entries are read only
// after they were written
// ----------------------------------------------------------------------------
module free_level_window_monitor_unit #(
  parameter int HIST_DEPTH   = 64,
  parameter int REGION_COUNT = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  flwm_in_if.sink                            in_ch,
  flwm_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [flwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [flwm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [31:0] int_warn_r, int_crit_r, ext_warn_r, ext_crit_r, hyst_r;
  logic [6:0]  win_len_r, hist_len_r;
  logic        frag_en_r;

  logic            push, fifo_full, q_valid, q_pop;
  flwm_pkg::item_t f_item, q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_warn_r <= '0;
      int_crit_r <= '0;
      ext_warn_r <= '0;
      ext_crit_r <= '0;
      hyst_r     <= '0;
      win_len_r  <= '0;
      hist_len_r <= '0;
      frag_en_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        flwm_pkg::CFG_INT_WARN: int_warn_r <= cfg_data;
        flwm_pkg::CFG_INT_CRIT: int_crit_r <= cfg_data;
        flwm_pkg::CFG_EXT_WARN: ext_warn_r <= cfg_data;
        flwm_pkg::CFG_EXT_CRIT: ext_crit_r <= cfg_data;
        flwm_pkg::CFG_HYST:     hyst_r     <= cfg_data;
        flwm_pkg::CFG_WIN_LEN:  win_len_r  <= cfg_data[6:0];
        flwm_pkg::CFG_HIST_LEN: hist_len_r <= cfg_data[6:0];
        flwm_pkg::CFG_FRAG_EN:  frag_en_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  flwm_front #(
    .REGION_COUNT (REGION_COUNT)
  ) u_front (
    .in_ch     (in_ch),
    .fifo_full (fifo_full),
    .int_warn  (int_warn_r),
    .int_crit  (int_crit_r),
    .ext_warn  (ext_warn_r),
    .ext_crit  (ext_crit_r),
    .push      (push),
    .item      (f_item)
  );

  flwm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .item_in  (f_item),
    .full     (fifo_full),
    .valid    (q_valid),
    .item_out (q_item),
    .pop      (q_pop)
  );

  flwm_back #(
    .HIST_DEPTH   (HIST_DEPTH),
    .REGION_COUNT (REGION_COUNT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .hyst     (hyst_r),
    .win_len  (win_len_r),
    .hist_len (hist_len_r),
    .frag_en  (frag_en_r),
    .out_ch   (out_ch)
  );

endmodule
